### rtl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Shared types, command and status structs, constants and round functions.
// ----------------------------------------------------------------------------
package sha1md_pkg;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  valid_bytes;
		logic        end_of_message;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        last_word;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_LEN,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SRC_ITEM,
		SRC_PAD,
		SRC_LEN
	} src_t;

	typedef struct packed {
		logic       accept;
		logic       load_block;
		src_t       src;
		logic       put_len;
		logic       round_en;
		logic [6:0] round_idx;
		logic       chain_add;
		logic       chain_init;
		logic [2:0] out_sel;
	} cmd_t;

	typedef struct packed {
		logic overflow;
		logic pad_two;
	} status_t;

	localparam logic [6:0]  LAST_ROUND = 7'd79;
	localparam logic [6:0]  ADD_STEP   = 7'd80;
	localparam logic [2:0]  LAST_SEL   = 3'd4;
	localparam logic [5:0]  LEN_POS    = 6'd56;
	localparam logic [7:0]  PAD_BYTE   = 8'h80;
	localparam logic [2:0]  WORD_BYTES = 3'd4;

	localparam logic [31:0] INIT_H0 = 32'h67452301;
	localparam logic [31:0] INIT_H1 = 32'hEFCDAB89;
	localparam logic [31:0] INIT_H2 = 32'h98BADCFE;
	localparam logic [31:0] INIT_H3 = 32'h10325476;
	localparam logic [31:0] INIT_H4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	function automatic logic [31:0] round_f(input logic [6:0] idx, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (idx < 7'd20) begin
			f = d ^ (b & (c ^ d));
		end else if (idx >= 7'd40 && idx < 7'd60) begin
			f = (b & c) | (d & (b | c));
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] idx);
		logic [31:0] k;
		if (idx < 7'd20) begin
			k = K0;
		end else if (idx < 7'd40) begin
			k = K1;
		end else if (idx < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

endpackage

### rtl/sha1_message_digest_core.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest core
// Hashes a byte message delivered as big-endian words and returns the digest.
// ----------------------------------------------------------------------------
// Usage:
// item channel (item_valid/item_ready/item) carries a word and its count of
// leading valid bytes; end_of_message marks the last transaction of a message.
// digest channel (digest_valid/digest_ready/digest) returns five words, word 0
// first, with last_word set on the fifth.
// Items are taken one per cycle until a 64-byte block fills; that block is
// then compressed (80 rounds and the chaining add) by the single round unit,
// while further items that do not fill the next block are still taken; an
// item that would fill it waits until the round unit is idle.
// After the last item the core waits for any running block, then compresses
// one or two padding blocks and offers the digest in the OUT state after FIN;
// no item is taken from then until the fifth word is taken.
// A stalled receiver holds the current digest word; the core simply waits.
// Reset loads the initial chaining value and clears the byte counts; the
// core is ready for items as soon as reset is released.
// ----------------------------------------------------------------------------
module sha1_message_digest_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  sha1md_pkg::item_t   item,
	output logic                digest_valid,
	input  logic                digest_ready,
	output sha1md_pkg::result_t digest
);

	sha1md_pkg::cmd_t    cmd;
	sha1md_pkg::status_t status;

	sha1md_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_last    (item.end_of_message),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.status       (status),
		.cmd          (cmd)
	);

	sha1md_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.digest (digest)
	);

endmodule

### rtl/sha1md_dp.sv
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Byte buffer, padding, message schedule window, round logic and chaining value.
// ----------------------------------------------------------------------------
module sha1md_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  sha1md_pkg::item_t  item,
	input  sha1md_pkg::cmd_t   cmd,
	output sha1md_pkg::status_t status,
	output sha1md_pkg::result_t digest
);

	logic [31:0] buf_q [16];
	logic [31:0] win_q [16];
	logic [31:0] wv_q [5];
	logic [31:0] chain_q [5];
	logic [5:0]  pos_q;
	logic [60:0] count_q;

	logic [2:0]  nbytes;
	logic [6:0]  fill;
	logic [7:0]  ibyte [4];
	logic [7:0]  buf_b [64];
	logic [7:0]  merged [64];
	logic [7:0]  wrapped [64];
	logic [7:0]  padded [64];
	logic [7:0]  src_bytes [64];
	logic [31:0] blk [16];
	logic [63:0] bit_len;
	logic [31:0] t_word;
	logic [31:0] sched_x;
	logic [31:0] f_word;

	always_comb begin
		nbytes = (item.valid_bytes > sha1md_pkg::WORD_BYTES) ? sha1md_pkg::WORD_BYTES
			: item.valid_bytes;
		fill = {1'b0, pos_q} + {4'b0000, nbytes};
		status.overflow = fill[6];
		status.pad_two = (pos_q >= sha1md_pkg::LEN_POS);
		bit_len = {count_q, 3'b000};
		for (int k = 0; k < 4; k++) begin
			ibyte[k] = item.data_word[(31 - 8 * k) -: 8];
		end
		for (int i = 0; i < 16; i++) begin
			for (int b = 0; b < 4; b++) begin
				buf_b[4 * i + b] = buf_q[i][(31 - 8 * b) -: 8];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 64; j++) begin
			merged[j] = buf_b[j];
			wrapped[j] = buf_b[j];
			if (6'(j) < pos_q) begin
				padded[j] = buf_b[j];
			end else if (6'(j) == pos_q) begin
				padded[j] = sha1md_pkg::PAD_BYTE;
			end else begin
				padded[j] = 8'h00;
			end
			for (int k = 0; k < 4; k++) begin
				if (3'(k) < nbytes) begin
					if (({1'b0, pos_q} + 7'(k)) == 7'(j)) begin
						merged[j] = ibyte[k];
					end
					if ((pos_q + 6'(k)) == 6'(j)) begin
						wrapped[j] = ibyte[k];
					end
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 64; j++) begin
			unique case (cmd.src)
				sha1md_pkg::SRC_ITEM: src_bytes[j] = merged[j];
				sha1md_pkg::SRC_PAD:  src_bytes[j] = padded[j];
				sha1md_pkg::SRC_LEN:  src_bytes[j] = 8'h00;
				default:              src_bytes[j] = 8'h00;
			endcase
		end
		for (int i = 0; i < 16; i++) begin
			blk[i] = {src_bytes[4 * i], src_bytes[4 * i + 1], src_bytes[4 * i + 2],
				src_bytes[4 * i + 3]};
		end
		if (cmd.put_len) begin
			blk[14] = bit_len[63:32];
			blk[15] = bit_len[31:0];
		end
	end

	always_comb begin
		f_word = sha1md_pkg::round_f(cmd.round_idx, wv_q[1], wv_q[2], wv_q[3]);
		t_word = {wv_q[0][26:0], wv_q[0][31:27]} + f_word + wv_q[4]
			+ sha1md_pkg::round_k(cmd.round_idx) + win_q[0];
		sched_x = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			for (int i = 0; i < 16; i++) begin
				buf_q[i] <= {wrapped[4 * i], wrapped[4 * i + 1], wrapped[4 * i + 2],
					wrapped[4 * i + 3]};
			end
		end
		if (cmd.load_block) begin
			for (int i = 0; i < 16; i++) begin
				win_q[i] <= blk[i];
			end
			for (int i = 0; i < 5; i++) begin
				wv_q[i] <= chain_q[i];
			end
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= {sched_x[30:0], sched_x[31]};
			wv_q[0] <= t_word;
			wv_q[1] <= wv_q[0];
			wv_q[2] <= {wv_q[1][1:0], wv_q[1][31:2]};
			wv_q[3] <= wv_q[2];
			wv_q[4] <= wv_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= sha1md_pkg::INIT_H0;
			chain_q[1] <= sha1md_pkg::INIT_H1;
			chain_q[2] <= sha1md_pkg::INIT_H2;
			chain_q[3] <= sha1md_pkg::INIT_H3;
			chain_q[4] <= sha1md_pkg::INIT_H4;
			pos_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.accept) begin
				pos_q <= fill[5:0];
				count_q <= count_q + {58'd0, nbytes};
			end
			if (cmd.load_block && (cmd.src != sha1md_pkg::SRC_ITEM)) begin
				pos_q <= '0;
			end
			if (cmd.chain_add) begin
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= chain_q[i] + wv_q[i];
				end
			end
			if (cmd.chain_init) begin
				chain_q[0] <= sha1md_pkg::INIT_H0;
				chain_q[1] <= sha1md_pkg::INIT_H1;
				chain_q[2] <= sha1md_pkg::INIT_H2;
				chain_q[3] <= sha1md_pkg::INIT_H3;
				chain_q[4] <= sha1md_pkg::INIT_H4;
				count_q <= '0;
			end
		end
	end

	always_comb begin
		case (cmd.out_sel)
			3'd0:    digest.digest_word = chain_q[0];
			3'd1:    digest.digest_word = chain_q[1];
			3'd2:    digest.digest_word = chain_q[2];
			3'd3:    digest.digest_word = chain_q[3];
			default: digest.digest_word = chain_q[4];
		endcase
		digest.last_word = (cmd.out_sel == sha1md_pkg::LAST_SEL);
	end

endmodule

### rtl/sha1md_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences item transactions, compression rounds, padding and digest output.
// ----------------------------------------------------------------------------
module sha1md_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic                item_last,
	output logic                digest_valid,
	input  logic                digest_ready,
	input  sha1md_pkg::status_t status,
	output sha1md_pkg::cmd_t    cmd
);

	sha1md_pkg::state_t state_q;
	sha1md_pkg::state_t state_d;
	logic               busy_q;
	logic [6:0]         round_q;
	logic [2:0]         sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1md_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		item_ready = 1'b0;
		digest_valid = 1'b0;
		cmd = '0;
		cmd.src = sha1md_pkg::SRC_ITEM;
		cmd.round_idx = round_q;
		cmd.round_en = busy_q && (round_q <= sha1md_pkg::LAST_ROUND);
		cmd.chain_add = busy_q && (round_q == sha1md_pkg::ADD_STEP);
		cmd.out_sel = sel_q;
		unique case (state_q)
			sha1md_pkg::ST_IDLE: begin
				item_ready = !(busy_q && status.overflow);
				if (item_valid && item_ready) begin
					cmd.accept = 1'b1;
					cmd.load_block = status.overflow;
					if (item_last) begin
						state_d = sha1md_pkg::ST_FLUSH;
					end
				end
			end
			sha1md_pkg::ST_FLUSH: begin
				if (!busy_q) begin
					cmd.load_block = 1'b1;
					cmd.src = sha1md_pkg::SRC_PAD;
					cmd.put_len = !status.pad_two;
					state_d = status.pad_two ? sha1md_pkg::ST_LEN : sha1md_pkg::ST_FIN;
				end
			end
			sha1md_pkg::ST_LEN: begin
				if (!busy_q) begin
					cmd.load_block = 1'b1;
					cmd.src = sha1md_pkg::SRC_LEN;
					cmd.put_len = 1'b1;
					state_d = sha1md_pkg::ST_FIN;
				end
			end
			sha1md_pkg::ST_FIN: begin
				if (!busy_q) begin
					state_d = sha1md_pkg::ST_OUT;
				end
			end
			sha1md_pkg::ST_OUT: begin
				digest_valid = 1'b1;
				if (digest_ready && (sel_q == sha1md_pkg::LAST_SEL)) begin
					cmd.chain_init = 1'b1;
					state_d = sha1md_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha1md_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			round_q <= '0;
			sel_q <= '0;
		end else begin
			if (cmd.load_block) begin
				busy_q <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				if (round_q == sha1md_pkg::ADD_STEP) begin
					busy_q <= 1'b0;
				end else begin
					round_q <= round_q + 7'd1;
				end
			end
			if (digest_valid && digest_ready) begin
				sel_q <= (sel_q == sha1md_pkg::LAST_SEL) ? 3'd0 : sel_q + 3'd1;
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_block |-> !busy_q)
		else $error("block load while compression active");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_block |=> busy_q && (round_q == 7'd0))
		else $error("compression did not start");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (round_q <= sha1md_pkg::ADD_STEP))
		else $error("round counter out of range");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (round_q == sha1md_pkg::ADD_STEP) |=> !busy_q)
		else $error("compression did not finish");

	a_out_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> !busy_q && (sel_q <= sha1md_pkg::LAST_SEL))
		else $error("digest shown while compression active");

endmodule
